@@ rtl/overlap_tile_axis_planner_core_macros.svh @@
// assertion macros for the overlapped tile planner
// used by the controller and datapath; expects clk and rst_n in scope
`ifndef OVERLAP_TILE_AXIS_PLANNER_CORE_MACROS_SVH
`define OVERLAP_TILE_AXIS_PLANNER_CORE_MACROS_SVH

// consequence holds in the same cycle as the trigger
`define OTAP_HOLDS(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the trigger
`define OTAP_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ rtl/otap_pkg.sv @@
// shared constants, codes and handshake types of the overlapped tile planner
// no dependencies
`default_nettype none

package otap_pkg;

  // tiling geometry
  localparam int TILE_SIZE     = 256;
  localparam int COMPRESSION   = 8;   // power of two
  localparam int MIN_OVERLAP   = 64;
  localparam int MAX_TILES_DEF = 16;
  localparam int ALIGNMENT     = 32;

  // field widths
  localparam int AXIS_W   = 12;
  localparam int NUM_W    = 4;
  localparam int LSTART_W = 9;
  localparam int BLEND_W  = 5;
  localparam int STITCH_W = 6;

  // internal widths
  localparam int REM_W   = $clog2(TILE_SIZE);
  localparam int EXTRA_W = $clog2(TILE_SIZE / COMPRESSION + 1);
  localparam int LAT_W   = $clog2(TILE_SIZE + MIN_OVERLAP + 1);

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_MISALIGN = 3'd2,
    ERR_TOO_MANY = 3'd3,
    ERR_LATENT   = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCREEN,
    ST_GROW,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic grow;
    logic div_init;
    logic div_step;
    logic emit;
    logic fail;
    err_t fail_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic too_short;
    logic misaligned;
    logic covered;
    logic at_max;
    logic latent_bad;
    logic single;
    logic div_done;
    logic last;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/otap_ctrl.sv @@
// sequencing state machine of the overlapped tile planner
// depends on otap_pkg and the assertion macro header
`default_nettype none

`include "overlap_tile_axis_planner_core_macros.svh"

module otap_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output otap_pkg::cmd_t    cmd,
  input  otap_pkg::status_t status
);

  otap_pkg::state_t state_r;
  otap_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= otap_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      otap_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = otap_pkg::ST_SCREEN;
        end
      end
      otap_pkg::ST_SCREEN: begin
        if (status.too_short) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = otap_pkg::ERR_SHORT;
          state_nxt     = otap_pkg::ST_IDLE;
        end else if (status.misaligned) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = otap_pkg::ERR_MISALIGN;
          state_nxt     = otap_pkg::ST_IDLE;
        end else begin
          state_nxt = otap_pkg::ST_GROW;
        end
      end
      otap_pkg::ST_GROW: begin
        if (status.covered) begin
          state_nxt = otap_pkg::ST_CHECK;
        end else if (status.at_max) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = otap_pkg::ERR_TOO_MANY;
          state_nxt     = otap_pkg::ST_IDLE;
        end else begin
          cmd.grow = 1'b1;
        end
      end
      otap_pkg::ST_CHECK: begin
        if (status.latent_bad) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = otap_pkg::ERR_LATENT;
          state_nxt     = otap_pkg::ST_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = status.single ? otap_pkg::ST_EMIT : otap_pkg::ST_DIV;
        end
      end
      otap_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_nxt = otap_pkg::ST_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      otap_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.last) begin
          state_nxt = otap_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = otap_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != otap_pkg::ST_IDLE);

  // checks
  `OTAP_NEXT(a_start_screen, (state_r == otap_pkg::ST_IDLE) && start, state_r == otap_pkg::ST_SCREEN, "accepted word did not enter screening")
  `OTAP_NEXT(a_last_idle, (state_r == otap_pkg::ST_EMIT) && status.last, state_r == otap_pkg::ST_IDLE, "no return to idle after last tile")
  `OTAP_HOLDS(a_fail_code, cmd.fail, cmd.fail_code != otap_pkg::ERR_NONE, "failure issued without error code")

endmodule

`default_nettype wire

@@ rtl/otap_dpath.sv @@
// datapath of the overlapped tile planner: tile count search, leftover
// split by a restoring divider, descriptor generation and output registers
// depends on otap_pkg and the assertion macro header
`default_nettype none

`include "overlap_tile_axis_planner_core_macros.svh"

module otap_dpath #(
  parameter int MAX_TILES = otap_pkg::MAX_TILES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  otap_pkg::cmd_t                  cmd,
  output otap_pkg::status_t               status,
  input  logic [otap_pkg::AXIS_W-1:0]     in_axis_length,
  output logic                            out_valid,
  output logic [otap_pkg::NUM_W-1:0]      out_tile_number,
  output logic [otap_pkg::AXIS_W-1:0]     out_pixel_start,
  output logic [otap_pkg::LSTART_W-1:0]   out_latent_start,
  output logic [otap_pkg::BLEND_W-1:0]    out_blend_before,
  output logic [otap_pkg::BLEND_W-1:0]    out_crop_after,
  output logic [otap_pkg::STITCH_W-1:0]   out_stitch_len,
  output logic [2:0]                      out_error_code,
  output logic                            out_last_tile
);

  localparam int CNT_W   = $clog2(MAX_TILES + 1);
  localparam int COV_RAW = $clog2(otap_pkg::TILE_SIZE * MAX_TILES + 1);
  localparam int COV_W   = ((COV_RAW > otap_pkg::AXIS_W) ? COV_RAW : otap_pkg::AXIS_W) + 2;
  localparam int EXT_W   = otap_pkg::EXTRA_W;
  localparam int DCNT_W  = $clog2(EXT_W + 1);
  localparam int LAT_W   = otap_pkg::LAT_W;
  localparam int REM_W   = otap_pkg::REM_W;
  localparam int AXIS_W  = otap_pkg::AXIS_W;

  localparam logic signed [COV_W-1:0] COVER_INIT = COV_W'(otap_pkg::TILE_SIZE);
  localparam logic signed [COV_W-1:0] COVER_STEP =
    COV_W'(otap_pkg::TILE_SIZE - otap_pkg::MIN_OVERLAP);
  localparam logic [LAT_W-1:0] MO_LAT =
    LAT_W'(otap_pkg::MIN_OVERLAP / otap_pkg::COMPRESSION);
  localparam logic [LAT_W-1:0] TILE_LAT =
    LAT_W'(otap_pkg::TILE_SIZE / otap_pkg::COMPRESSION);
  localparam logic [AXIS_W-1:0] PIX_BASE =
    AXIS_W'(otap_pkg::TILE_SIZE - otap_pkg::MIN_OVERLAP);

  // search and divider state
  logic [AXIS_W-1:0]       len_r;
  logic [CNT_W-1:0]        n_r;
  logic signed [COV_W-1:0] cover_r;
  logic [EXT_W-1:0]        quo_r;
  logic [CNT_W-1:0]        part_r;
  logic [DCNT_W-1:0]       dcnt_r;
  logic [CNT_W-1:0]        cursor_r;
  logic [AXIS_W-1:0]       start_r;

  // output registers
  logic                           out_valid_r;
  logic [otap_pkg::NUM_W-1:0]     out_tile_number_r;
  logic [AXIS_W-1:0]              out_pixel_start_r;
  logic [otap_pkg::LSTART_W-1:0]  out_latent_start_r;
  logic [otap_pkg::BLEND_W-1:0]   out_blend_before_r;
  logic [otap_pkg::BLEND_W-1:0]   out_crop_after_r;
  logic [otap_pkg::STITCH_W-1:0]  out_stitch_len_r;
  otap_pkg::err_t                 out_error_code_r;
  logic                           out_last_tile_r;

  logic signed [COV_W-1:0] len_s;
  logic signed [COV_W-1:0] rem_full;
  logic [REM_W-1:0]        rem;
  logic [EXT_W-1:0]        extra;
  logic [CNT_W-1:0]        dvs;
  logic [CNT_W:0]          trial;
  logic [CNT_W:0]          diff;
  logic                    take;
  logic                    last;
  logic [LAT_W-1:0]        units_cur;
  logic [LAT_W-1:0]        units_prev;
  logic [LAT_W-1:0]        blend_full;
  logic [LAT_W-1:0]        crop_full;
  logic [LAT_W-1:0]        stitch_full;
  logic [AXIS_W-1:0]       pix_step;

  // coverage test and leftover
  assign len_s    = signed'(COV_W'(len_r));
  assign rem_full = cover_r - len_s;
  assign rem      = REM_W'(rem_full);
  assign extra    = EXT_W'(rem / REM_W'(otap_pkg::COMPRESSION));

  // one restoring divide step: leftover units over the number of overlaps
  assign dvs   = n_r - CNT_W'(1);
  assign trial = {part_r, quo_r[EXT_W-1]};
  assign take  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  // per tile overlap units, quotient plus one for the leading overlaps
  assign last       = (cursor_r == n_r - CNT_W'(1));
  assign units_cur  = LAT_W'(quo_r) + ((cursor_r < part_r) ? LAT_W'(1) : LAT_W'(0));
  assign units_prev = LAT_W'(quo_r) + ((cursor_r <= part_r) ? LAT_W'(1) : LAT_W'(0));
  assign blend_full = (cursor_r == '0) ? '0 : MO_LAT + units_prev;
  assign crop_full  = last ? '0 : MO_LAT + units_cur;
  assign stitch_full = (crop_full > TILE_LAT) ? '0 : TILE_LAT - crop_full;
  assign pix_step   = PIX_BASE - AXIS_W'(otap_pkg::COMPRESSION * units_cur);

  // status to the controller
  always_comb begin
    status.too_short  = (len_r < AXIS_W'(otap_pkg::TILE_SIZE));
    status.misaligned = ((len_r % AXIS_W'(otap_pkg::ALIGNMENT)) != '0);
    status.covered    = (cover_r >= len_s);
    status.at_max     = (n_r == CNT_W'(MAX_TILES));
    status.latent_bad = ((rem % REM_W'(otap_pkg::COMPRESSION)) != '0);
    status.single     = (n_r == CNT_W'(1));
    status.div_done   = (dcnt_r == DCNT_W'(EXT_W));
    status.last       = last;
  end

  // tile count search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r   <= in_axis_length;
      n_r     <= CNT_W'(1);
      cover_r <= COVER_INIT;
    end else if (cmd.grow) begin
      n_r     <= n_r + CNT_W'(1);
      cover_r <= cover_r + COVER_STEP;
    end
  end

  // divider and emission cursor
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r    <= extra;
      part_r   <= '0;
      dcnt_r   <= '0;
      cursor_r <= '0;
      start_r  <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[EXT_W-2:0], take};
      part_r <= take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end else if (cmd.emit) begin
      cursor_r <= cursor_r + CNT_W'(1);
      start_r  <= start_r + pix_step;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit | cmd.fail;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      out_tile_number_r   <= '0;
      out_pixel_start_r   <= '0;
      out_latent_start_r  <= '0;
      out_blend_before_r  <= '0;
      out_crop_after_r    <= '0;
      out_stitch_len_r    <= '0;
      out_error_code_r    <= cmd.fail_code;
      out_last_tile_r     <= 1'b1;
    end else if (cmd.emit) begin
      out_tile_number_r   <= otap_pkg::NUM_W'(cursor_r);
      out_pixel_start_r   <= start_r;
      out_latent_start_r  <=
        otap_pkg::LSTART_W'(start_r / AXIS_W'(otap_pkg::COMPRESSION));
      out_blend_before_r  <= otap_pkg::BLEND_W'(blend_full);
      out_crop_after_r    <= otap_pkg::BLEND_W'(crop_full);
      out_stitch_len_r    <= otap_pkg::STITCH_W'(stitch_full);
      out_error_code_r    <= otap_pkg::ERR_NONE;
      out_last_tile_r     <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tile_number   = out_tile_number_r;
  assign out_pixel_start   = out_pixel_start_r;
  assign out_latent_start  = out_latent_start_r;
  assign out_blend_before  = out_blend_before_r;
  assign out_crop_after    = out_crop_after_r;
  assign out_stitch_len    = out_stitch_len_r;
  assign out_error_code    = out_error_code_r;
  assign out_last_tile     = out_last_tile_r;

  // checks
  `OTAP_HOLDS(a_err_last, out_valid_r && (out_error_code_r != otap_pkg::ERR_NONE), out_last_tile_r, "error word without last flag")
  `OTAP_NEXT(a_emit_strobe, cmd.emit || cmd.fail, out_valid_r, "issued word not strobed")

endmodule

`default_nettype wire

@@ rtl/overlap_tile_axis_planner_core.sv @@
// Overlapped tile planner, one axis length in, one descriptor per tile out.
// Flow: screening, tile count search, latent check, restoring divider of 6 steps, then emission.
// A single tile skips the divider; words are then emitted one a cycle until the last tile.
// Rejected lengths strobe one error word, flagged as the last tile, instead of descriptors.
// Results cannot be stalled; each word is shown for one cycle with out_valid.
// Reset: synchronous active-low rst_n returns to idle with no strobe pending.
`default_nettype none

module overlap_tile_axis_planner_core #(
  parameter int MAX_TILES = otap_pkg::MAX_TILES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [otap_pkg::AXIS_W-1:0]     in_axis_length,
  output logic                            out_valid,
  output logic [otap_pkg::NUM_W-1:0]      out_tile_number,
  output logic [otap_pkg::AXIS_W-1:0]     out_pixel_start,
  output logic [otap_pkg::LSTART_W-1:0]   out_latent_start,
  output logic [otap_pkg::BLEND_W-1:0]    out_blend_before,
  output logic [otap_pkg::BLEND_W-1:0]    out_crop_after,
  output logic [otap_pkg::STITCH_W-1:0]   out_stitch_len,
  output logic [2:0]                      out_error_code,
  output logic                            out_last_tile
);

  otap_pkg::cmd_t    cmd;
  otap_pkg::status_t status;

  // sequencer
  otap_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // arithmetic and result registers
  otap_dpath #(
    .MAX_TILES (MAX_TILES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_axis_length    (in_axis_length),
    .out_valid         (out_valid),
    .out_tile_number   (out_tile_number),
    .out_pixel_start   (out_pixel_start),
    .out_latent_start  (out_latent_start),
    .out_blend_before  (out_blend_before),
    .out_crop_after    (out_crop_after),
    .out_stitch_len    (out_stitch_len),
    .out_error_code    (out_error_code),
    .out_last_tile     (out_last_tile)
  );

endmodule

`default_nettype wire
